[hdl/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
// No dependencies; imported by spq_cell and stable_priority_queue.
package spq_pkg;

  localparam int SPQ_DEPTH     = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int TAG_BITS      = 16;
  localparam int COUNT_BITS    = 5;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     op;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0]      tag;
  } in_item_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]      out_tag;
    logic [PRIORITY_BITS-1:0] out_priority;
    status_t                  status;
    logic [COUNT_BITS-1:0]    count;
  } out_item_t;

  // one stored entry
  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

[hdl/stable_priority_queue.sv]
// Stable priority queue: a row of DEPTH cells kept sorted by priority, lower
// value first, equal priorities in arrival order. Each transaction (push or
// pop) is applied to all cells at once: every cell compares the incoming
// priority with its own and either holds, loads the new entry or takes its
// neighbor's, so one transaction per cycle is sustained unless the output
// stalls, and the result appears in the output register the cycle after
// acceptance. The input is taken whenever the output register is empty or
// its result is being taken in the same cycle. Depends on spq_pkg and spq_cell.
module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_item_t          out_data_r;
  out_item_t          out_data_nxt;

  logic               accept;
  cell_ctl_t          ctl;
  entry_t             new_ent;
  entry_t             cell_ent [DEPTH];
  logic [DEPTH-1:0]   cell_keep;
  logic [DEPTH-1:0]   occ;
  logic               is_full;
  logic               is_empty;
  logic [COUNT_W+COUNT_BITS-1:0] count_ext;

  // accept when the output register is free or drains this cycle
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_full  = (count_r == COUNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  assign new_ent.prio = in_data.priority_req;
  assign new_ent.tag  = in_data.tag;

  // command to the chain
  always_comb begin
    ctl.push = accept && (in_data.op == OP_PUSH) && !is_full;
    ctl.pop  = accept && (in_data.op == OP_POP) && !is_empty;
  end

  // occupancy per slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (COUNT_W'(i) < count_r);
    end
  end

  // build the chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_keep;

    if (g == 0) begin : g_head
      assign left_ent  = new_ent;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = cell_ent[g-1];
      assign left_keep = cell_keep[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_ent = cell_ent[g];
    end else begin : g_body
      assign right_ent = cell_ent[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .occ       (occ[g]),
      .left_keep (left_keep),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (cell_ent[g]),
      .keep      (cell_keep[g])
    );
  end

  // update the held count
  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  assign count_ext = {{COUNT_BITS{1'b0}}, count_nxt};

  // form the result transaction
  always_comb begin
    out_data_nxt              = out_data_r;
    out_valid_nxt             = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.out_tag       = '0;
      out_data_nxt.out_priority  = '0;
      out_data_nxt.status        = STAT_OK;
      out_data_nxt.count         = count_ext[COUNT_BITS-1:0];
      if (in_data.op == OP_PUSH) begin
        if (is_full) begin
          out_data_nxt.status = STAT_FULL;
        end
      end else begin
        if (is_empty) begin
          out_data_nxt.status = STAT_EMPTY;
        end else begin
          out_data_nxt.out_tag      = cell_ent[0].tag;
          out_data_nxt.out_priority = cell_ent[0].prio;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

[hdl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t   new_ent,
  input  logic              occ,
  input  logic              left_keep,
  input  spq_pkg::entry_t   left_ent,
  input  spq_pkg::entry_t   right_ent,
  output spq_pkg::entry_t   ent,
  output logic              keep
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // stay in place on push if held entry is at least as urgent as the new one
  assign keep = occ && (ent_r.prio <= new_ent.prio);
  assign ent  = ent_r;

  // insert, shift right on push; shift left on pop
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.push) begin
      if (!keep) begin
        ent_nxt = left_keep ? new_ent : left_ent;
      end
    end else if (ctl.pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
